/* hdl/rtph264_pkg.sv */
// Shared constants for the RTP H.264 depacketizer.
// No dependencies; used by rtp_h264_depacketizer.
package rtph264_pkg;

  localparam int unsigned MaxPacketBytes = 2048;

  localparam int unsigned HdrLenW     = 6;
  localparam logic [5:0]  HdrLenReset = 6'd12;

  // NAL unit types of interest
  localparam logic [4:0] NalSingleMax = 5'd23;
  localparam logic [4:0] NalFuA       = 5'd28;
  localparam logic [4:0] NalFuB       = 5'd29;

  // Annex-B start code 00 00 00 01 plus the NAL header byte
  localparam logic [7:0] StartCodeZero = 8'h00;
  localparam logic [7:0] StartCodeOne  = 8'h01;
  localparam logic [2:0] BurstLen      = 3'd5;
  localparam logic [2:0] SingleLen     = 3'd1;

endpackage

/* hdl/rtp_h264_depacketizer.sv */
// RTP H.264 depacketizer top level: RTP bytes in, Annex-B byte stream out.
// Depends on rtph264_pkg.
//
// Usage:
//   Input channel: one RTP packet byte per transaction (data_byte_i), with
//   last_byte_i set on the final byte. Output channel: one Annex-B byte per
//   transaction; byte_valid_o low marks a bare end marker, end_of_packet_o
//   flags the last result of each packet. Both channels use valid/stall;
//   the receiver drives stall.
//   cfg_we_i/cfg_wdata_i write header_len (RTP header bytes to skip); write
//   only while the block is idle.
// Flow:
//   A byte is registered at the input stage; its results are then registered
//   in the result register and driven out from there.
//   A byte that opens a NAL unit yields start code plus header, five results
//   drained one per cycle while the receiver does not stall; other bytes with
//   results yield one result. Bytes yielding nothing leave the input stage
//   even while the result register is busy.
// Reset: asynchronous, active low; clears the pipeline, returns the parser
//   to header skip and header_len to 12. No clearing pass.
// Stall: when the receiver stalls, the result holds; a byte with results then
//   waits in the input stage with in_stall_o high until results drain.
module rtp_h264_depacketizer #(
  parameter int unsigned MAX_PACKET_BYTES = rtph264_pkg::MaxPacketBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_packet_o,
  input  logic       cfg_we_i,
  input  logic [rtph264_pkg::HdrLenW-1:0] cfg_wdata_i
);

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET_BYTES);

  typedef enum logic [2:0] {
    ModeSkip,
    ModeFuHdr,
    ModeSingle,
    ModeFuPay,
    ModeDiscard
  } mode_e;

  // configuration
  logic [rtph264_pkg::HdrLenW-1:0] hdr_len_q;

  // input stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // parser state
  mode_e           mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      fnri_q, fnri_d;

  // result register: remaining results of the current burst
  logic [2:0] rem_q, rem_d;
  logic [7:0] hdr_q, hdr_d;
  logic       bval_q, bval_d;
  logic       eop_q, eop_d;

  // per-byte decode
  logic [2:0] n_res;
  logic [7:0] res_byte;
  logic       res_bval;

  logic in_accept, out_take, buf_free, s1_move;
  logic [4:0] nal_type;

  assign nal_type = s1_byte_q[4:0];

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    fnri_d   = fnri_q;
    n_res    = 3'd0;
    res_byte = s1_byte_q;
    res_bval = 1'b1;
    if (pos_q < PosMax) begin
      unique case (mode_q)
        ModeSkip: begin
          if (pos_q >= PosW'(hdr_len_q)) begin
            priority if (nal_type != 5'd0 && nal_type <= rtph264_pkg::NalSingleMax) begin
              n_res  = rtph264_pkg::BurstLen;
              mode_d = ModeSingle;
            end else if (nal_type == rtph264_pkg::NalFuA ||
                         nal_type == rtph264_pkg::NalFuB) begin
              fnri_d = s1_byte_q[7:5];
              mode_d = ModeFuHdr;
            end else begin
              mode_d = ModeDiscard;
            end
          end
        end
        ModeFuHdr: begin
          // start bit without end bit: rebuild the NAL header
          if (s1_byte_q[7] && !s1_byte_q[6]) begin
            n_res    = rtph264_pkg::BurstLen;
            res_byte = {fnri_q, s1_byte_q[4:0]};
          end
          mode_d = ModeFuPay;
        end
        ModeSingle, ModeFuPay: begin
          n_res = rtph264_pkg::SingleLen;
        end
        default: begin
          mode_d = ModeDiscard;
        end
      endcase
      pos_d = pos_q + PosW'(1);
    end
    if (s1_last_q) begin
      if (n_res == 3'd0) begin
        // bare end marker
        n_res    = rtph264_pkg::SingleLen;
        res_byte = 8'h00;
        res_bval = 1'b0;
      end
      mode_d = ModeSkip;
      pos_d  = '0;
      fnri_d = 3'd0;
    end
  end

  assign out_valid_o = (rem_q != 3'd0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign buf_free    = !out_valid_o || (rem_q == 3'd1 && out_take);
  // bytes with no result never wait for the result register
  assign s1_move     = s1_valid_q && ((n_res == 3'd0) || buf_free);
  assign in_stall_o  = s1_valid_q && !s1_move;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_move);

  always_comb begin
    rem_d  = rem_q;
    hdr_d  = hdr_q;
    bval_d = bval_q;
    eop_d  = eop_q;
    if (s1_move && n_res != 3'd0) begin
      rem_d  = n_res;
      hdr_d  = res_byte;
      bval_d = res_bval;
      eop_d  = s1_last_q;
    end else if (out_take) begin
      rem_d = rem_q - 3'd1;
    end
  end

  // Drive the start code bytes first, then the stored header or payload byte.
  always_comb begin
    unique case (rem_q)
      3'd5, 3'd4, 3'd3: out_byte_o = rtph264_pkg::StartCodeZero;
      3'd2:             out_byte_o = rtph264_pkg::StartCodeOne;
      default:          out_byte_o = hdr_q;
    endcase
  end
  assign byte_valid_o    = (rem_q != 3'd1) || bval_q;
  assign end_of_packet_o = (rem_q == 3'd1) && eop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_len_q  <= rtph264_pkg::HdrLenReset;
      s1_valid_q <= 1'b0;
      mode_q     <= ModeSkip;
      pos_q      <= '0;
      fnri_q     <= 3'd0;
      rem_q      <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        hdr_len_q <= cfg_wdata_i;
      end
      s1_valid_q <= s1_valid_d;
      // advance the parser only when the byte leaves the input stage
      if (s1_move) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        fnri_q <= fnri_d;
      end
      rem_q <= rem_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    hdr_q  <= hdr_d;
    bval_q <= bval_d;
    eop_q  <= eop_d;
  end

endmodule

/* hdl/rtph264_checker.sv */
// Port-level checks for rtp_h264_depacketizer, attached with bind.
// Depends only on the top-level ports.
module rtph264_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       end_of_packet_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(byte_valid_o) && $stable(end_of_packet_o))
    else $error("stalled result changed");

  // a result without a stream byte is only the bare end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> end_of_packet_o && out_byte_o == 8'h00)
    else $error("bare marker malformed");

  // input only backs up behind a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

endmodule

bind rtp_h264_depacketizer rtph264_checker u_rtph264_checker (.*);

/* dv/tb_rtp_h264_depacketizer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rtp_h264_depacketizer: directed packets, then random RTP packets.
// Depends on rtph264_pkg and the rtp_h264_depacketizer RTL only.
module tb_rtp_h264_depacketizer;

  localparam int unsigned CycleLimit = 1_000_000;

  typedef logic [rtph264_pkg::HdrLenW-1:0] hlen_t;

  // One Annex-B output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eop;
  } annexb_t;

  // Parser phase inside one packet
  typedef enum logic [2:0] {
    PM_SKIP,
    PM_FU_HDR,
    PM_SINGLE,
    PM_FU_PAY,
    PM_DISCARD
  } pkt_mode_e;

  // How a directed row gets its expected results
  typedef enum logic [2:0] {
    CHK_MODEL,   // from the predictor
    CHK_NONE,    // no results at all
    CHK_MARKER,  // one bare end marker
    CHK_PASS,    // one stream byte, end flag follows last_byte
    CHK_BURST    // start code plus header byte
  } chk_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    int         cfg;    // header_len written before this row, -1 for none
    chk_e       kind;
    logic [7:0] want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte = 8'h00;
  logic                last_byte = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                byte_valid;
  logic                end_of_packet;
  logic                cfg_we = 1'b0;
  hlen_t               cfg_wdata = '0;

  // Predictor state: mirrors the parser and its one register
  hlen_t               hlen = rtph264_pkg::HdrLenReset;
  int unsigned         pos = 0;
  pkt_mode_e           mode = PM_SKIP;
  logic [2:0]          f_nri = 3'd0;
  annexb_t             step_out[$];

  annexb_t             annexb_q[$];     // stream bytes still owed by the block
  int unsigned         mismatch_cnt = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         sent_items = 0;
  bit                  in_nogap = 1'b0;
  bit                  out_nostall = 1'b0;

  // Directed packets. Header length stays at its reset value for the first
  // packet, then drops to zero so each packet opens with its NAL or fragment header byte.
  dir_row_t dir_rows [0:26] = '{
    '{8'hFF, 1'b0, -1, CHK_NONE,   8'h00},  // header byte, skipped
    '{8'h00, 1'b1, -1, CHK_MARKER, 8'h00},  // packet ends inside the header
    '{8'h65, 1'b0,  0, CHK_BURST,  8'h65},  // single NAL, type 5
    '{8'h00, 1'b0, -1, CHK_PASS,   8'h00},
    '{8'hFF, 1'b1, -1, CHK_PASS,   8'hFF},
    '{8'h7C, 1'b0, -1, CHK_NONE,   8'h00},  // FU-A indicator, NRI 3
    '{8'h85, 1'b0, -1, CHK_BURST,  8'h65},  // start fragment, header rebuilt
    '{8'hAA, 1'b1, -1, CHK_PASS,   8'hAA},
    '{8'hFC, 1'b0, -1, CHK_NONE,   8'h00},  // F set, NRI 3
    '{8'h9F, 1'b0, -1, CHK_MODEL,  8'h00},  // start fragment, type 31
    '{8'h01, 1'b1, -1, CHK_PASS,   8'h01},
    '{8'h9C, 1'b0, -1, CHK_NONE,   8'h00},
    '{8'h41, 1'b0, -1, CHK_NONE,   8'h00},  // end fragment: payload only
    '{8'h55, 1'b1, -1, CHK_PASS,   8'h55},
    '{8'h1D, 1'b0, -1, CHK_NONE,   8'h00},  // FU-B indicator
    '{8'hC7, 1'b0, -1, CHK_NONE,   8'h00},  // start and end both set
    '{8'h12, 1'b1, -1, CHK_PASS,   8'h12},
    '{8'hE1, 1'b1, -1, CHK_BURST,  8'hE1},  // one-byte single NAL packet
    '{8'h18, 1'b0, -1, CHK_NONE,   8'h00},  // type 24 discards the packet
    '{8'h33, 1'b1, -1, CHK_MARKER, 8'h00},
    '{8'h00, 1'b1, -1, CHK_MARKER, 8'h00},  // type 0
    '{8'h3C, 1'b1, -1, CHK_MARKER, 8'h00},  // ends before fragment header
    '{8'h37, 1'b0, -1, CHK_BURST,  8'h37},  // type 23, top single type
    '{8'h5F, 1'b1, -1, CHK_PASS,   8'h5F},
    '{8'h1F, 1'b1, -1, CHK_MARKER, 8'h00},  // type 31
    '{8'h7D, 1'b0, -1, CHK_NONE,   8'h00},  // FU-B, NRI 3
    '{8'h80, 1'b1, -1, CHK_MODEL,  8'h00}   // start fragment on the last byte
  };

  rtp_h264_depacketizer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_byte_o      (out_byte),
    .byte_valid_o    (byte_valid),
    .end_of_packet_o (end_of_packet),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void push_start_code();
    step_out.push_back('{rtph264_pkg::StartCodeZero, 1'b1, 1'b0});
    step_out.push_back('{rtph264_pkg::StartCodeZero, 1'b1, 1'b0});
    step_out.push_back('{rtph264_pkg::StartCodeZero, 1'b1, 1'b0});
    step_out.push_back('{rtph264_pkg::StartCodeOne, 1'b1, 1'b0});
  endfunction

  // Work out the stream bytes one packet byte yields and advance the parser.
  function automatic void depack_step(input logic [7:0] b, input logic l);
    logic [4:0] nal_type;
    nal_type = b[4:0];
    step_out.delete();
    if (pos < rtph264_pkg::MaxPacketBytes) begin
      case (mode)
        PM_SKIP: begin
          if (pos >= hlen) begin
            if (nal_type >= 5'd1 && nal_type <= rtph264_pkg::NalSingleMax) begin
              push_start_code();
              step_out.push_back('{b, 1'b1, 1'b0});
              mode = PM_SINGLE;
            end else if (nal_type == rtph264_pkg::NalFuA ||
                         nal_type == rtph264_pkg::NalFuB) begin
              f_nri = b[7:5];
              mode = PM_FU_HDR;
            end else begin
              mode = PM_DISCARD;
            end
          end
        end
        PM_FU_HDR: begin
          // end bit wins over start bit
          if (b[7] && !b[6]) begin
            push_start_code();
            step_out.push_back('{{f_nri, b[4:0]}, 1'b1, 1'b0});
          end
          mode = PM_FU_PAY;
        end
        PM_SINGLE, PM_FU_PAY: step_out.push_back('{b, 1'b1, 1'b0});
        default: mode = PM_DISCARD;
      endcase
      pos++;
    end
    if (l) begin
      if (step_out.size() == 0) step_out.push_back('{8'h00, 1'b0, 1'b1});
      else step_out[$].eop = 1'b1;
      pos = 0;
      mode = PM_SKIP;
      f_nri = 3'd0;
    end
  endfunction

  // Offer one packet byte, hold it until the transaction completes, then
  // record what it owes. Called and returning at a rising edge.
  task automatic send_byte(input logic [7:0] d, input logic l, input chk_e kind,
                           input logic [7:0] want);
    int gap;
    gap = in_nogap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    sent_items++;
    depack_step(d, l);
    case (kind)
      CHK_MODEL: foreach (step_out[i]) annexb_q.push_back(step_out[i]);
      CHK_MARKER: annexb_q.push_back('{8'h00, 1'b0, 1'b1});
      CHK_PASS: annexb_q.push_back('{want, 1'b1, l});
      CHK_BURST: begin
        annexb_q.push_back('{rtph264_pkg::StartCodeZero, 1'b1, 1'b0});
        annexb_q.push_back('{rtph264_pkg::StartCodeZero, 1'b1, 1'b0});
        annexb_q.push_back('{rtph264_pkg::StartCodeZero, 1'b1, 1'b0});
        annexb_q.push_back('{rtph264_pkg::StartCodeOne, 1'b1, 1'b0});
        annexb_q.push_back('{want, 1'b1, l});
      end
      default: ;
    endcase
  endtask

  // Drain the block, let it settle, then write header_len.
  task automatic write_hlen(input hlen_t v);
    in_valid <= 1'b0;
    while (annexb_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hlen = v;
  endtask

  // Build one packet: mostly well-formed single NAL or fragment packets with
  // random content, some unsupported types and some cut short.
  task automatic send_random_packet();
    logic [7:0] pkt[$];
    int         kind;
    int         pay_len;
    int         keep;
    int         utype;
    kind = $urandom_range(0, 99);
    in_nogap = ($urandom_range(0, 3) == 0);
    repeat (hlen) pkt.push_back(8'($urandom));
    if (kind < 45) begin
      pkt.push_back({3'($urandom), 5'($urandom_range(1, rtph264_pkg::NalSingleMax))});
    end else if (kind < 85 || kind >= 93) begin
      pkt.push_back({3'($urandom),
                     ($urandom_range(0, 1) ? rtph264_pkg::NalFuA : rtph264_pkg::NalFuB)});
      pkt.push_back(8'($urandom));   // S, E, R and type all random
    end else begin
      utype = $urandom_range(23, 31);
      if (utype == 23 || utype == rtph264_pkg::NalFuA || utype == rtph264_pkg::NalFuB) begin
        utype = 0;
      end
      pkt.push_back({3'($urandom), 5'(utype)});
    end
    pay_len = $urandom_range(0, 12);
    repeat (pay_len) pkt.push_back(8'($urandom));
    // Short packet: stop at or before the fragment indicator
    if (kind >= 93) begin
      keep = $urandom_range(1, hlen + 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, CHK_MODEL, 8'h00);
  endtask

  // Receiver: stall a random number of cycles before each transaction, with
  // occasional stretches of no stalling at all.
  initial begin : rx_stall
    int wait_n;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) out_nostall = ~out_nostall;
      wait_n = out_nostall ? 0 : $urandom_range(0, 10);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare every output transaction with the oldest owed byte.
  always @(posedge clk) begin : result_check
    annexb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (annexb_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte=%02h valid=%0b eop=%0b",
                 $time, out_byte, byte_valid, end_of_packet);
        mismatch_cnt++;
      end else begin
        want = annexb_q.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.data, out_byte);
          mismatch_cnt++;
        end
        if (byte_valid !== want.valid) begin
          $display("%0t: byte_valid mismatch: expected %0b, actual %0b",
                   $time, want.valid, byte_valid);
          mismatch_cnt++;
        end
        if (end_of_packet !== want.eop) begin
          $display("%0t: end_of_packet mismatch: expected %0b, actual %0b",
                   $time, want.eop, end_of_packet);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int hlen_set [0:4];
    int next_hlen;
    int phase_start;
    hlen_set = '{12, 63, 0, 1, -1};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) write_hlen(hlen_t'(dir_rows[i].cfg));
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].kind, dir_rows[i].want);
    end

    // Random part: one phase per header length, extremes included
    foreach (hlen_set[p]) begin
      next_hlen = (hlen_set[p] < 0) ? $urandom_range(2, 62) : hlen_set[p];
      write_hlen(hlen_t'(next_hlen));
      phase_start = sent_items;
      while (sent_items - phase_start < 64) send_random_packet();
    end

    // Drain and let the pipeline settle before judging
    in_valid <= 1'b0;
    while (annexb_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
